// ===== rtl/core/jeue_pkg.sv =====
package jeue_pkg;

  localparam int unsigned CP_W   = 21;
  localparam int unsigned BYTE_W = 8;
  localparam int unsigned IDX_W  = 3;

  localparam logic [CP_W-1:0] CP_LIMIT   = 21'h10FFFF;
  localparam logic [CP_W-1:0] CP_CTRL_HI = 21'h00001F;
  localparam logic [CP_W-1:0] CP_UTF1_HI = 21'h00007F;
  localparam logic [CP_W-1:0] CP_UTF2_HI = 21'h0007FF;
  localparam logic [CP_W-1:0] CP_UTF3_HI = 21'h00FFFF;

  localparam logic [CP_W-1:0] CP_QUOTE  = 21'h000022;
  localparam logic [CP_W-1:0] CP_BSLASH = 21'h00005C;
  localparam logic [CP_W-1:0] CP_SOLID  = 21'h00002F;
  localparam logic [CP_W-1:0] CP_BS     = 21'h000008;
  localparam logic [CP_W-1:0] CP_FF     = 21'h00000C;
  localparam logic [CP_W-1:0] CP_LF     = 21'h00000A;
  localparam logic [CP_W-1:0] CP_CR     = 21'h00000D;
  localparam logic [CP_W-1:0] CP_TAB    = 21'h000009;

  localparam logic [BYTE_W-1:0] CH_BSLASH = 8'h5C;
  localparam logic [BYTE_W-1:0] CH_QUOTE  = 8'h22;
  localparam logic [BYTE_W-1:0] CH_SOLID  = 8'h2F;
  localparam logic [BYTE_W-1:0] CH_B      = 8'h62;
  localparam logic [BYTE_W-1:0] CH_F      = 8'h66;
  localparam logic [BYTE_W-1:0] CH_N      = 8'h6E;
  localparam logic [BYTE_W-1:0] CH_R      = 8'h72;
  localparam logic [BYTE_W-1:0] CH_T      = 8'h74;
  localparam logic [BYTE_W-1:0] CH_U      = 8'h75;
  localparam logic [BYTE_W-1:0] CH_ZERO   = 8'h30;

  localparam logic [BYTE_W-1:0] LEAD_2 = 8'hC0;
  localparam logic [BYTE_W-1:0] LEAD_3 = 8'hE0;
  localparam logic [BYTE_W-1:0] LEAD_4 = 8'hF0;
  localparam logic [BYTE_W-1:0] CONT   = 8'h80;

  typedef enum logic [2:0] {
    K_ESC2,
    K_UESC,
    K_UTF1,
    K_UTF2,
    K_UTF3,
    K_UTF4,
    K_DROP
  } kind_t;

  typedef struct packed {
    kind_t           kind;
    logic [CP_W-1:0] cp;
  } entry_t;

  function automatic logic [BYTE_W-1:0] hex_digit(input logic [3:0] nib);
    logic [BYTE_W-1:0] ch;
    case (nib)
      4'h0: ch = 8'h30;
      4'h1: ch = 8'h31;
      4'h2: ch = 8'h32;
      4'h3: ch = 8'h33;
      4'h4: ch = 8'h34;
      4'h5: ch = 8'h35;
      4'h6: ch = 8'h36;
      4'h7: ch = 8'h37;
      4'h8: ch = 8'h38;
      4'h9: ch = 8'h39;
      4'hA: ch = 8'h41;
      4'hB: ch = 8'h42;
      4'hC: ch = 8'h43;
      4'hD: ch = 8'h44;
      4'hE: ch = 8'h45;
      4'hF: ch = 8'h46;
      default: ch = 8'h30;
    endcase
    return ch;
  endfunction

endpackage

// ===== rtl/core/jeue_front.sv =====
module jeue_front (
  input  logic                     push,
  output logic                     full,
  input  logic [jeue_pkg::CP_W-1:0] in_code_point,
  input  logic                     q_full,
  output logic                     q_wr,
  output jeue_pkg::entry_t         q_wdata
);
  import jeue_pkg::*;

  kind_t kind;

  always_comb begin
    case (in_code_point)
      CP_QUOTE, CP_BSLASH, CP_SOLID, CP_BS, CP_FF, CP_LF, CP_CR, CP_TAB: kind = K_ESC2;
      default: begin
        if (in_code_point <= CP_CTRL_HI) begin
          kind = K_UESC;
        end else if (in_code_point <= CP_UTF1_HI) begin
          kind = K_UTF1;
        end else if (in_code_point <= CP_UTF2_HI) begin
          kind = K_UTF2;
        end else if (in_code_point <= CP_UTF3_HI) begin
          kind = K_UTF3;
        end else if (in_code_point <= CP_LIMIT) begin
          kind = K_UTF4;
        end else begin
          kind = K_DROP;
        end
      end
    endcase
  end

  assign full          = q_full;
  assign q_wr          = push && !q_full && (kind != K_DROP);
  assign q_wdata.kind  = kind;
  assign q_wdata.cp    = in_code_point;

endmodule

// ===== rtl/core/jeue_queue.sv =====
module jeue_queue #(
  parameter int unsigned DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             wr,
  input  jeue_pkg::entry_t wdata,
  output logic             q_full,
  input  logic             rd,
  output jeue_pkg::entry_t rdata,
  output logic             q_empty
);
  import jeue_pkg::*;

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  entry_t          mem_r [DEPTH];
  logic [PW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]   count_r,  count_nxt;
  logic            do_wr, do_rd;

  assign q_full  = (count_r == CW'(DEPTH));
  assign q_empty = (count_r == '0);
  assign do_wr   = wr && !q_full;
  assign do_rd   = rd && !q_empty;
  assign rdata   = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_wr) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_rd) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_wr && !do_rd) begin
      count_nxt = count_r + 1'b1;
    end else if (do_rd && !do_wr) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

endmodule

// ===== rtl/core/jeue_back.sv =====
module jeue_back (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        q_empty,
  input  jeue_pkg::entry_t            q_head,
  output logic                        q_rd,
  output logic                        empty,
  input  logic                        pop,
  output logic [jeue_pkg::BYTE_W-1:0] out_byte,
  output logic                        out_last_byte
);
  import jeue_pkg::*;

  logic [IDX_W-1:0]  idx_r, idx_nxt;
  logic              out_v_r, out_v_nxt;
  logic [BYTE_W-1:0] out_byte_r;
  logic              out_last_r;
  logic [BYTE_W-1:0] byte_sel;
  logic [BYTE_W-1:0] esc_ch;
  logic [IDX_W-1:0]  len_m1;
  logic              is_last;
  logic              load;
  logic [CP_W-1:0]   cp;

  assign cp = q_head.cp;

  always_comb begin
    case (cp[7:0])
      CP_QUOTE[7:0]:  esc_ch = CH_QUOTE;
      CP_BSLASH[7:0]: esc_ch = CH_BSLASH;
      CP_SOLID[7:0]:  esc_ch = CH_SOLID;
      CP_BS[7:0]:     esc_ch = CH_B;
      CP_FF[7:0]:     esc_ch = CH_F;
      CP_LF[7:0]:     esc_ch = CH_N;
      CP_CR[7:0]:     esc_ch = CH_R;
      CP_TAB[7:0]:    esc_ch = CH_T;
      default:        esc_ch = CH_BSLASH;
    endcase
  end

  always_comb begin
    byte_sel = '0;
    len_m1   = '0;
    case (q_head.kind)
      K_ESC2: begin
        len_m1   = IDX_W'(1);
        byte_sel = (idx_r == '0) ? CH_BSLASH : esc_ch;
      end
      K_UESC: begin
        len_m1 = IDX_W'(5);
        case (idx_r)
          IDX_W'(0): byte_sel = CH_BSLASH;
          IDX_W'(1): byte_sel = CH_U;
          IDX_W'(2): byte_sel = CH_ZERO;
          IDX_W'(3): byte_sel = CH_ZERO;
          IDX_W'(4): byte_sel = hex_digit(cp[7:4]);
          default:   byte_sel = hex_digit(cp[3:0]);
        endcase
      end
      K_UTF1: begin
        len_m1   = '0;
        byte_sel = cp[7:0];
      end
      K_UTF2: begin
        len_m1   = IDX_W'(1);
        byte_sel = (idx_r == '0) ? (LEAD_2 | {3'b000, cp[10:6]}) : (CONT | {2'b00, cp[5:0]});
      end
      K_UTF3: begin
        len_m1 = IDX_W'(2);
        case (idx_r)
          IDX_W'(0): byte_sel = LEAD_3 | {4'h0, cp[15:12]};
          IDX_W'(1): byte_sel = CONT | {2'b00, cp[11:6]};
          default:   byte_sel = CONT | {2'b00, cp[5:0]};
        endcase
      end
      K_UTF4: begin
        len_m1 = IDX_W'(3);
        case (idx_r)
          IDX_W'(0): byte_sel = LEAD_4 | {5'b00000, cp[20:18]};
          IDX_W'(1): byte_sel = CONT | {2'b00, cp[17:12]};
          IDX_W'(2): byte_sel = CONT | {2'b00, cp[11:6]};
          default:   byte_sel = CONT | {2'b00, cp[5:0]};
        endcase
      end
      default: begin
        len_m1   = '0;
        byte_sel = '0;
      end
    endcase
  end

  assign is_last = (idx_r == len_m1);
  assign load    = (!out_v_r || pop) && !q_empty;
  assign q_rd    = load && is_last;

  always_comb begin
    idx_nxt   = idx_r;
    out_v_nxt = out_v_r;
    if (pop && out_v_r) begin
      out_v_nxt = 1'b0;
    end
    if (load) begin
      out_v_nxt = 1'b1;
      idx_nxt   = is_last ? '0 : idx_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r   <= '0;
      out_v_r <= 1'b0;
    end else begin
      idx_r   <= idx_nxt;
      out_v_r <= out_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_byte_r <= byte_sel;
      out_last_r <= is_last;
    end
  end

  assign empty         = !out_v_r;
  assign out_byte      = out_byte_r;
  assign out_last_byte = out_last_r;

endmodule

// ===== rtl/core/json_escape_utf8_encode.sv =====
// Channel   Valid/ready      Payload
// input     push / full      in_code_point[20:0]
// result    !empty / pop     out_byte[7:0], out_last_byte
//
// One code point is taken per cycle while the classify queue has room.
// The byte sequencer sends one byte per cycle unless pop stalls. A code
// point of 1 to 6 bytes is queued, then each byte is registered for output.
// Code points above 0x10FFFF are taken and make no bytes.
// Reset clears the queue and the output valid flag; a stalled pop backs up
// the queue and then raises full.
module json_escape_utf8_encode #(
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        push,
  output logic                        full,
  input  logic [jeue_pkg::CP_W-1:0]   in_code_point,
  output logic                        empty,
  input  logic                        pop,
  output logic [jeue_pkg::BYTE_W-1:0] out_byte,
  output logic                        out_last_byte
);
  import jeue_pkg::*;

  entry_t q_wdata;
  entry_t q_head;
  logic   q_wr, q_full, q_rd, q_empty;

  jeue_front u_front (
    .push          (push),
    .full          (full),
    .in_code_point (in_code_point),
    .q_full        (q_full),
    .q_wr          (q_wr),
    .q_wdata       (q_wdata)
  );

  jeue_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr      (q_wr),
    .wdata   (q_wdata),
    .q_full  (q_full),
    .rd      (q_rd),
    .rdata   (q_head),
    .q_empty (q_empty)
  );

  jeue_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .q_empty       (q_empty),
    .q_head        (q_head),
    .q_rd          (q_rd),
    .empty         (empty),
    .pop           (pop),
    .out_byte      (out_byte),
    .out_last_byte (out_last_byte)
  );

endmodule
